>>> design/slrl_pkg.sv
package slrl_pkg;

    localparam int DEF_RING_DEPTH = 128;
    localparam int DEF_TIME_WIDTH = 32;

    localparam logic [7:0]  DEF_MAX_REQUESTS = 8'd120;
    localparam logic [31:0] DEF_WINDOW_TICKS = 32'd60000;

    // Two registers, max_requests (8 bits) and window_ticks (32 bits), at byte addresses 0 and 4.
    localparam int CFG_ADDR_W = 3;

    localparam logic REG_MAX_REQUESTS = 1'b0;
    localparam logic REG_WINDOW_TICKS = 1'b1;

    typedef struct packed {
        logic load;    // capture the request time
        logic pop;     // drop the oldest stamp
        logic decide;  // admit or deny, load the result register
    } slrl_cmd_t;

    typedef struct packed {
        logic expired; // oldest held stamp lies outside the window
        logic room;    // held count is below the effective limit
    } slrl_status_t;

endpackage

>>> design/slrl_ram.sv
module slrl_ram #(
    parameter int WIDTH = slrl_pkg::DEF_TIME_WIDTH,
    parameter int DEPTH = slrl_pkg::DEF_RING_DEPTH
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/slrl_cfg.sv
module slrl_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [slrl_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output logic [7:0]                      max_requests,
    output logic [31:0]                     window_ticks
);
    import slrl_pkg::*;

    logic [7:0]  max_requests_reg;
    logic [31:0] window_ticks_reg;
    logic        reg_index;
    logic        wr_en;

    assign reg_index = paddr[2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_requests_reg <= DEF_MAX_REQUESTS;
            window_ticks_reg <= DEF_WINDOW_TICKS;
        end else if (wr_en) begin
            unique case (reg_index)
                REG_MAX_REQUESTS: max_requests_reg <= pwdata[7:0];
                REG_WINDOW_TICKS: window_ticks_reg <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_MAX_REQUESTS: prdata = {24'd0, max_requests_reg};
            REG_WINDOW_TICKS: prdata = window_ticks_reg;
        endcase
    end

    assign max_requests = max_requests_reg;
    assign window_ticks = window_ticks_reg;

endmodule

>>> design/slrl_dp.sv
module slrl_dp #(
    parameter int RING_DEPTH = slrl_pkg::DEF_RING_DEPTH,
    parameter int TIME_WIDTH = slrl_pkg::DEF_TIME_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  slrl_pkg::slrl_cmd_t    cmd,
    output slrl_pkg::slrl_status_t status,
    input  logic [31:0]            now_time,
    input  logic [7:0]             max_requests,
    input  logic [31:0]            window_ticks,
    output logic                   allowed,
    output logic [7:0]             held_count
);
    import slrl_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int LIM_W = (CNT_W > 8) ? CNT_W : 8;

    logic [TIME_WIDTH-1:0] now_reg;
    logic [PTR_W-1:0]      ptr_reg, ptr_next, ptr_inc, slot;
    logic [CNT_W-1:0]      count_reg, count_next, count_after;
    logic                  allowed_reg;
    logic [7:0]            held_reg;

    logic [TIME_WIDTH-1:0] rdata, age, win;
    logic [LIM_W-1:0]      max_ext, depth_ext, limit;
    logic [SUM_W-1:0]      slot_sum;
    logic                  push;

    // Ages wrap modulo 2^TIME_WIDTH, so a plain subtraction is enough.
    assign age = now_reg - rdata;
    assign win = TIME_WIDTH'(window_ticks);

    assign max_ext   = LIM_W'(max_requests);
    assign depth_ext = LIM_W'(RING_DEPTH);
    assign limit     = (max_ext > depth_ext) ? depth_ext : max_ext;

    assign status.expired = (count_reg != '0) && (age > win);
    assign status.room    = LIM_W'(count_reg) < limit;

    assign push = cmd.decide && status.room;

    assign ptr_inc  = (ptr_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
    assign ptr_next = cmd.pop ? ptr_inc : ptr_reg;

    // The young end lies count entries past the oldest, at most one wrap away.
    assign slot_sum = SUM_W'(ptr_reg) + SUM_W'(count_reg);
    assign slot     = (slot_sum >= SUM_W'(RING_DEPTH)) ?
                      PTR_W'(slot_sum - SUM_W'(RING_DEPTH)) : PTR_W'(slot_sum);

    assign count_after = push ? count_reg + 1'b1 : count_reg;
    assign count_next  = cmd.pop ? count_reg - 1'b1 : count_after;

    // The read address follows the next pointer, so the oldest stamp waits on the
    // read port in the next cycle, unless a write to that address came in the same cycle.
    slrl_ram #(
        .WIDTH (TIME_WIDTH),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (push),
        .waddr (slot),
        .wdata (now_reg),
        .raddr (ptr_next),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg   <= '0;
            count_reg <= '0;
        end else begin
            ptr_reg   <= ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            now_reg <= TIME_WIDTH'(now_time);
        end
        if (cmd.decide) begin
            allowed_reg <= push;
            held_reg    <= 8'(count_after);
        end
    end

    assign allowed    = allowed_reg;
    assign held_count = held_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(RING_DEPTH))
        else $error("held count exceeds ring depth");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> (count_reg != '0))
        else $error("stamp dropped from an empty ring");

    a_push_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg < CNT_W'(RING_DEPTH)))
        else $error("stamp written over a held entry");

endmodule

>>> design/slrl_ctrl.sv
module slrl_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  slrl_pkg::slrl_status_t status,
    output slrl_pkg::slrl_cmd_t    cmd
);
    import slrl_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXPIRE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_ready;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXPIRE;
                end
            end
            S_EXPIRE: begin
                if (status.expired) begin
                    cmd.pop = 1'b1;
                end else if (!out_valid_reg || m_ready) begin
                    cmd.decide     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;

    a_accept_expire: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_EXPIRE))
        else $error("accepted request did not start expiry");

    a_decide_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.decide |=> m_valid)
        else $error("decision did not produce a result");

    a_pop_or_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.pop && cmd.decide))
        else $error("pop and decision in the same cycle");

endmodule

>>> design/sliding_log_rate_limiter.sv
// Sliding-window-log rate limiter. Each request transaction carries the current time;
// the block first drops every held timestamp older than the window, then admits the
// request and logs its time if fewer than max_requests (clamped to RING_DEPTH) stamps
// remain, and returns allowed plus the held count. The request time is captured, then
// expired stamps are dropped one at a time, then the decision is made; the stamp memory
// has one registered read port and yields one stamp per cycle. The decision also waits
// while the previous result still sits unread in the output register. Each stamp
// expires at most once. A new request is taken while the previous result still waits
// in the output register. Write configuration only while idle.
module sliding_log_rate_limiter #(
    parameter int RING_DEPTH = slrl_pkg::DEF_RING_DEPTH,
    parameter int TIME_WIDTH = slrl_pkg::DEF_TIME_WIDTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [slrl_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [31:0]                     s_now_time,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_allowed,
    output logic [7:0]                      m_held_count
);
    import slrl_pkg::*;

    slrl_cmd_t    cmd;
    slrl_status_t status;
    logic [7:0]   max_requests;
    logic [31:0]  window_ticks;

    slrl_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .max_requests (max_requests),
        .window_ticks (window_ticks)
    );

    slrl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    slrl_dp #(
        .RING_DEPTH (RING_DEPTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .now_time     (s_now_time),
        .max_requests (max_requests),
        .window_ticks (window_ticks),
        .allowed      (m_allowed),
        .held_count   (m_held_count)
    );

endmodule

>>> bench/sliding_log_rate_limiter_test.sv
`timescale 1ns / 100ps

module sliding_log_rate_limiter_test;

    import slrl_pkg::*;

    localparam int DEPTH = DEF_RING_DEPTH;

    typedef struct {
        logic       allowed;
        logic [7:0] held_count;
    } verdict_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_valid;
    logic                  s_ready;
    logic [31:0]           s_now_time;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_allowed;
    logic [7:0]            m_held_count;

    // Local copy of the limiter state, updated as each request is accepted.
    logic [31:0] stamp_log [DEPTH];
    int          log_head;
    int          log_count;
    logic [7:0]  cfg_limit;
    logic [31:0] cfg_window;

    verdict_t verdict_q [$];
    verdict_t want_verdict;
    int       error_count;
    int       send_gap_max;
    int       recv_stall_max;
    int       recv_hold_cycles;

    sliding_log_rate_limiter u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_now_time   (s_now_time),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_allowed    (m_allowed),
        .m_held_count (m_held_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [CFG_ADDR_W-1:0] reg_addr(input logic idx);
        return {idx, 2'b00};
    endfunction

    // Expire old stamps, then admit the request if there is room under the clamped limit.
    function automatic void admit_request(input logic [31:0] stamp);
        int       limit;
        verdict_t v;
        limit = (cfg_limit > DEPTH) ? DEPTH : int'(cfg_limit);
        while (log_count > 0 && (stamp - stamp_log[log_head]) > cfg_window) begin
            log_head = (log_head + 1) % DEPTH;
            log_count--;
        end
        v.allowed = 1'b0;
        if (log_count < limit) begin
            stamp_log[(log_head + log_count) % DEPTH] = stamp;
            log_count++;
            v.allowed = 1'b1;
        end
        v.held_count = 8'(log_count);
        verdict_q = {verdict_q, v};
    endfunction

    // Result checker: every result transaction is matched against the oldest verdict.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                $error("unexpected result: allowed=%0d held_count=%0d",
                       m_allowed, m_held_count);
                error_count++;
            end else begin
                want_verdict = verdict_q[0];
                verdict_q.delete(0);
                if (m_allowed !== want_verdict.allowed) begin
                    $error("allowed: expected %0d, got %0d",
                           want_verdict.allowed, m_allowed);
                    error_count++;
                end
                if (m_held_count !== want_verdict.held_count) begin
                    $error("held_count: expected %0d, got %0d",
                           want_verdict.held_count, m_held_count);
                    error_count++;
                end
            end
        end
    end

    // Result receiver. A requested hold-off is counted here, in cycles.
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = $urandom_range(0, recv_stall_max);
            if (recv_hold_cycles > 0) begin
                stall = recv_hold_cycles;
                recv_hold_cycles = 0;
            end
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    task automatic send_request(input logic [31:0] stamp);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_now_time <= stamp;
        do @(posedge aclk); while (s_ready !== 1'b1);
        admit_request(stamp);
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
    endtask

    task automatic apb_write(input logic idx, input logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= reg_addr(idx);
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read_check(input logic idx, input logic [31:0] want,
                                  input logic [31:0] mask, input string name);
        logic [31:0] got;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= reg_addr(idx);
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        got = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if ((got & mask) !== (want & mask)) begin
            $error("%s: expected %0d, got %0d", name, want & mask, got & mask);
            error_count++;
        end
    endtask

    // Registers change only once the block has returned every result.
    task automatic set_limits(input logic [7:0] limit, input logic [31:0] window);
        wait_for_results();
        apb_write(REG_MAX_REQUESTS, {24'd0, limit});
        cfg_limit = limit;
        apb_write(REG_WINDOW_TICKS, window);
        cfg_window = window;
        apb_read_check(REG_MAX_REQUESTS, {24'd0, cfg_limit}, 32'h0000_00ff, "max_requests");
        apb_read_check(REG_WINDOW_TICKS, cfg_window, 32'hffff_ffff, "window_ticks");
    endtask

    task automatic test_reset_defaults();
        send_request(32'd0);
        send_request(32'd1);
        send_request(32'd60000);
        send_request(32'd60001);
    endtask

    // A zero window keeps only stamps with exactly the current time.
    task automatic test_zero_window();
        set_limits(8'd2, 32'd0);
        send_request(32'd5);
        send_request(32'd5);
        send_request(32'd5);
        send_request(32'd6);
    endtask

    task automatic test_zero_limit();
        set_limits(8'd0, 32'd1000);
        send_request(32'd100);
        send_request(32'hffff_ffff);
    endtask

    // Stamps across the wrap of the time counter, then one earlier than the last, then an all-ones window.
    task automatic test_time_wrap();
        set_limits(8'd4, 32'd10);
        send_request(32'hffff_fffa);
        send_request(32'hffff_ffff);
        send_request(32'd3);
        send_request(32'd5);
        send_request(32'd2);
        set_limits(8'd3, 32'hffff_ffff);
        send_request(32'hffff_ffff);
        send_request(32'd0);
        send_request(32'h8000_0000);
    endtask

    task automatic test_random_phases(input int phases, input int per_phase);
        logic [7:0]  limit;
        logic [31:0] window;
        logic [31:0] stamp;
        int          step_max;
        int          count;
        for (int p = 0; p < phases; p++) begin
            step_max = 1 << $urandom_range(0, 12);
            count    = per_phase;
            case (p)
                0: begin
                    limit  = 8'd255;
                    window = 32'hffff_ffff;
                    count  = per_phase + 40;
                end
                1: begin
                    limit  = 8'(DEPTH);
                    window = 32'd0;
                end
                2: begin
                    limit  = 8'd1;
                    window = 32'(step_max);
                end
                3: begin
                    limit  = 8'd0;
                    window = $urandom;
                end
                default: begin
                    case ($urandom_range(0, 9))
                        0: limit = 8'd1;
                        1: limit = 8'($urandom_range(DEPTH + 1, 255));
                        2: limit = 8'(DEPTH);
                        default: limit = 8'($urandom_range(2, 16));
                    endcase
                    case ($urandom_range(0, 9))
                        0: window = 32'd0;
                        1: window = 32'hffff_ffff;
                        2: window = $urandom;
                        default: window = $urandom_range(0, int'(limit) * step_max);
                    endcase
                end
            endcase
            set_limits(limit, window);
            // Some phases run with no idling on either side.
            send_gap_max   = (p % 5 == 4) ? 0 : 4;
            recv_stall_max = send_gap_max;
            stamp = ($urandom_range(0, 3) == 0) ? 32'hffff_ffff - $urandom_range(0, 5000)
                                                : $urandom;
            for (int i = 0; i < count; i++) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_request($urandom);
                end else begin
                    stamp = stamp + $urandom_range(0, step_max);
                    send_request(stamp);
                end
            end
        end
        send_gap_max   = 4;
        recv_stall_max = 4;
    endtask

    // The receiver stalls for a long stretch while requests keep coming, then the
    // sender pauses until every result is back before it resumes.
    task automatic test_backpressure();
        logic [31:0] stamp;
        set_limits(8'd64, 32'd200);
        stamp            = $urandom;
        send_gap_max     = 0;
        recv_hold_cycles = 400;
        for (int i = 0; i < 120; i++) begin
            stamp = stamp + $urandom_range(0, 8);
            send_request(stamp);
        end
        send_gap_max = 4;
        for (int i = 0; i < 40; i++) begin
            stamp = stamp + $urandom_range(0, 8);
            send_request(stamp);
        end
        wait_for_results();
        for (int i = 0; i < 40; i++) begin
            stamp = stamp + $urandom_range(0, 8);
            send_request(stamp);
        end
    endtask

    initial begin
        aresetn          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        s_valid          = 1'b0;
        s_now_time       = '0;
        error_count      = 0;
        send_gap_max     = 4;
        recv_stall_max   = 4;
        recv_hold_cycles = 0;
        log_head         = 0;
        log_count        = 0;
        cfg_limit        = DEF_MAX_REQUESTS;
        cfg_window       = DEF_WINDOW_TICKS;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_zero_window();
        test_zero_limit();
        test_time_wrap();
        test_random_phases(17, 100);
        test_backpressure();

        wait_for_results();
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
